// ===== hdl/rva_pkg.sv =====
// ----------------------------------------------------------------------------
// rva_pkg
// Shared types, constants and tables for the axis rotation pipeline.
// ----------------------------------------------------------------------------
package rva_pkg;

  // default number of cordic iterations and fraction bits of cos / sin
  localparam int TrigBitsDef = 18;

  // one full turn in 1/128 degree units; 46080 = 45 * 2^10
  localparam int TurnUnits = 46080;
  localparam int TurnDiv   = 45;
  // 2^32 / 46080 = 2^22 / 45
  localparam int TurnFrac  = 22;

  // m / 45 for m < 2^16 as (m * RecipMul) >> RecipShift
  localparam logic [16:0] RecipMul   = 17'd93207;
  localparam int          RecipShift = 22;
  localparam int          QuotW      = 10;

  // cordic gain correction, 2^32 scale
  localparam logic [63:0] CordicK = 64'd2608131496;

  // axis codes
  localparam logic [1:0] AxisX    = 2'd0;
  localparam logic [1:0] AxisY    = 2'd1;
  localparam logic [1:0] AxisZ    = 2'd2;
  localparam logic [1:0] AxisNone = 2'd3;

  // arctan(2^-i) as a 32-bit binary angle
  localparam logic [31:0] AtanTab [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1,         32'd0
  };

  typedef logic [TurnFrac-1:0] frac_tab_t [64];

  // low part of the binary angle for remainder r: floor((r * 2^22 + 22) / 45)
  function automatic frac_tab_t build_frac_tab();
    frac_tab_t tab;
    for (int r = 0; r < 64; r++) begin
      if (r < TurnDiv) begin
        tab[r] = TurnFrac'((64'(r) * (64'd1 << TurnFrac) + 64'd22) / 64'(TurnDiv));
      end else begin
        tab[r] = '0;
      end
    end
    return tab;
  endfunction

  localparam frac_tab_t FracTab = build_frac_tab();

  // vector and axis carried alongside the angle path
  typedef struct packed {
    logic [1:0]         axis;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } side_t;

endpackage

// ===== hdl/rva_angle.sv =====
// ----------------------------------------------------------------------------
// rva_angle
// Three-stage conversion of a degree angle into a folded 32-bit binary angle.
// ----------------------------------------------------------------------------
module rva_angle import rva_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  side_t              side_i,
  input  logic signed [16:0] angle_i,
  output logic               valid_o,
  output side_t              side_o,
  output logic signed [31:0] z_o,
  output logic               flip_o
);

  localparam logic signed [17:0] Turn = 18'(TurnUnits);

  logic               vld_a_q, vld_b_q, vld_c_q;
  side_t              side_a_q, side_b_q, side_c_q;
  logic signed [17:0] ang_ext;
  logic signed [17:0] ang_red;
  logic [15:0]        m_d, m_q, mb_q;
  logic [32:0]        prod;
  logic [QuotW-1:0]   q_d, q_q;
  logic [15:0]        rem;
  logic [31:0]        t;
  logic               flip_d, flip_q;
  logic signed [31:0] z_d, z_q;

  // stage a: reduce modulo one turn
  always_comb begin
    ang_ext = 18'(angle_i);
    priority if (ang_ext < -Turn) begin
      ang_red = ang_ext + Turn + Turn;
    end else if (ang_ext < 18'sd0) begin
      ang_red = ang_ext + Turn;
    end else if (ang_ext >= Turn) begin
      ang_red = ang_ext - Turn;
    end else begin
      ang_red = ang_ext;
    end
    m_d = ang_red[15:0];
  end

  // stage b: quotient by 45 through the reciprocal
  assign prod = 33'(m_q) * 33'(RecipMul);
  assign q_d  = prod[RecipShift+QuotW-1:RecipShift];

  // stage c: remainder picks the low bits, then fold into [-90, 90) degrees
  always_comb begin
    rem    = mb_q - 16'(q_q) * 16'(TurnDiv);
    t      = {q_q, FracTab[rem[5:0]]};
    flip_d = t[31] ^ t[30];
    z_d    = {t[31] ^ flip_d, t[30:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side_a_q <= side_i;
    m_q      <= m_d;
    side_b_q <= side_a_q;
    q_q      <= q_d;
    mb_q     <= m_q;
    side_c_q <= side_b_q;
    z_q      <= z_d;
    flip_q   <= flip_d;
  end

  assign valid_o = vld_c_q;
  assign side_o  = side_c_q;
  assign z_o     = z_q;
  assign flip_o  = flip_q;

endmodule

// ===== hdl/rva_cordic.sv =====
// ----------------------------------------------------------------------------
// rva_cordic
// Unrolled rotation-mode cordic, one registered iteration per stage.
// ----------------------------------------------------------------------------
module rva_cordic import rva_pkg::*; #(
  parameter int TrigBits = TrigBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  side_t                       side_i,
  input  logic                        flip_i,
  input  logic signed [31:0]          z_i,
  output logic                        valid_o,
  output side_t                       side_o,
  output logic                        flip_o,
  output logic signed [TrigBits+2:0]  x_o,
  output logic signed [TrigBits+2:0]  y_o
);

  localparam int W  = TrigBits + 3;
  localparam int Sh = 32 - TrigBits;
  localparam logic [63:0] XInitWide =
    (Sh == 0) ? CordicK : ((CordicK + (64'd1 << (Sh - 1))) >> Sh);
  localparam logic signed [W-1:0] XInit = W'(XInitWide);

  logic               vld_q  [TrigBits];
  logic               flip_q [TrigBits];
  side_t              side_q [TrigBits];
  logic signed [W-1:0] x_q   [TrigBits];
  logic signed [W-1:0] y_q   [TrigBits];
  logic signed [31:0]  z_q   [TrigBits];

  for (genvar i = 0; i < TrigBits; i++) begin : g_stage
    localparam logic signed [31:0] Step = AtanTab[i];

    logic                vld_in, flip_in;
    side_t               side_in;
    logic signed [W-1:0] x_in, y_in, dx, dy;
    logic signed [31:0]  z_in;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign flip_in = flip_i;
      assign side_in = side_i;
      assign x_in    = XInit;
      assign y_in    = '0;
      assign z_in    = z_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign flip_in = flip_q[i-1];
      assign side_in = side_q[i-1];
      assign x_in    = x_q[i-1];
      assign y_in    = y_q[i-1];
      assign z_in    = z_q[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      flip_q[i] <= flip_in;
      side_q[i] <= side_in;
      if (!z_in[31]) begin
        x_q[i] <= x_in - dx;
        y_q[i] <= y_in + dy;
        z_q[i] <= z_in - Step;
      end else begin
        x_q[i] <= x_in + dx;
        y_q[i] <= y_in - dy;
        z_q[i] <= z_in + Step;
      end
    end
  end

  assign valid_o = vld_q[TrigBits-1];
  assign side_o  = side_q[TrigBits-1];
  assign flip_o  = flip_q[TrigBits-1];
  assign x_o     = x_q[TrigBits-1];
  assign y_o     = y_q[TrigBits-1];

endmodule

// ===== hdl/rva_mix.sv =====
// ----------------------------------------------------------------------------
// rva_mix
// Clamps cos / sin, applies the 2x2 rotation with rounding and saturation.
// ----------------------------------------------------------------------------
module rva_mix import rva_pkg::*; #(
  parameter int TrigBits = TrigBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  side_t                       side_i,
  input  logic                        flip_i,
  input  logic signed [TrigBits+2:0]  x_i,
  input  logic signed [TrigBits+2:0]  y_i,
  output logic                        valid_o,
  output logic signed [31:0]          out_x_o,
  output logic signed [31:0]          out_y_o,
  output logic signed [31:0]          out_z_o,
  output logic                        saturated_o
);

  localparam int W     = TrigBits + 3;
  localparam int CW    = TrigBits + 2;
  localparam int ProdW = TrigBits + 34;
  localparam int SumW  = ProdW + 1;
  localparam int ShW   = SumW - TrigBits;

  localparam logic signed [W-1:0]    Lim = W'(1) << TrigBits;
  localparam logic signed [SumW-1:0] Rnd = SumW'(1) << (TrigBits - 1);

  logic                 vld1_q, vld2_q, vld3_q, vld4_q;
  side_t                side1_q, side2_q, side3_q;

  // stage 1
  logic signed [W-1:0]  xc, yc, xn, yn;
  logic signed [CW-1:0] c_d, s_d, c_q, s_q;
  logic signed [31:0]   a_d, b_d, a_q, b_q;
  // stage 2
  logic signed [ProdW-1:0] p_ac_q, p_bs_q, p_as_q, p_bc_q;
  // stage 3
  logic signed [SumW-1:0] sum1, sum2;
  logic signed [ShW-1:0]  r1_q, r2_q;
  // stage 4
  logic                 ovf1, ovf2;
  logic signed [31:0]   s1, s2;
  logic signed [31:0]   ox_d, oy_d, oz_d, ox_q, oy_q, oz_q;
  logic                 sat_d, sat_q;

  // clamp to one, undo the half-turn fold, pick the rotated pair
  always_comb begin
    xc = x_i;
    yc = y_i;
    if (x_i > Lim)  xc = Lim;
    if (x_i < -Lim) xc = -Lim;
    if (y_i > Lim)  yc = Lim;
    if (y_i < -Lim) yc = -Lim;
    xn  = flip_i ? -xc : xc;
    yn  = flip_i ? -yc : yc;
    c_d = CW'(xn);
    s_d = CW'(yn);
    unique case (side_i.axis)
      AxisX: begin
        a_d = side_i.vy;
        b_d = side_i.vz;
      end
      AxisY: begin
        a_d = side_i.vz;
        b_d = side_i.vx;
      end
      default: begin
        a_d = side_i.vx;
        b_d = side_i.vy;
      end
    endcase
  end

  // round half up then floor shift
  always_comb begin
    sum1 = SumW'(p_ac_q) + SumW'(p_bs_q) + Rnd;
    sum2 = SumW'(p_bc_q) - SumW'(p_as_q) + Rnd;
  end

  // saturate to 32 bits and place by axis
  always_comb begin
    ovf1 = (r1_q[ShW-1:31] != '0) && (r1_q[ShW-1:31] != '1);
    ovf2 = (r2_q[ShW-1:31] != '0) && (r2_q[ShW-1:31] != '1);
    s1   = ovf1 ? (r1_q[ShW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff) : r1_q[31:0];
    s2   = ovf2 ? (r2_q[ShW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff) : r2_q[31:0];
    ox_d  = side3_q.vx;
    oy_d  = side3_q.vy;
    oz_d  = side3_q.vz;
    sat_d = ovf1 | ovf2;
    unique case (side3_q.axis)
      AxisX: begin
        oy_d = s1;
        oz_d = s2;
      end
      AxisY: begin
        oz_d = s1;
        ox_d = s2;
      end
      AxisZ: begin
        ox_d = s1;
        oy_d = s2;
      end
      default: begin
        sat_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side1_q <= side_i;
    c_q     <= c_d;
    s_q     <= s_d;
    a_q     <= a_d;
    b_q     <= b_d;
    side2_q <= side1_q;
    p_ac_q  <= ProdW'(a_q) * ProdW'(c_q);
    p_bs_q  <= ProdW'(b_q) * ProdW'(s_q);
    p_as_q  <= ProdW'(a_q) * ProdW'(s_q);
    p_bc_q  <= ProdW'(b_q) * ProdW'(c_q);
    side3_q <= side2_q;
    r1_q    <= sum1[SumW-1:TrigBits];
    r2_q    <= sum2[SumW-1:TrigBits];
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    oz_q    <= oz_d;
    sat_q   <= sat_d;
  end

  assign valid_o     = vld4_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_z_o     = oz_q;
  assign saturated_o = sat_q;

endmodule

// ===== hdl/rotate_vector_about_axis.sv =====
// throughput: one vector per cycle; busy stays low, the pipeline never stalls
// the depth comes from one cordic iteration per stage plus the angle and mix stages
// reset clears the stage valid bits only; vectors in flight are dropped
// ----------------------------------------------------------------------------
// rotate_vector_about_axis
// Rotates a Q16.16 vector about the X, Y or Z axis by an angle in 1/128 degrees.
// ----------------------------------------------------------------------------
module rotate_vector_about_axis import rva_pkg::*; #(
  parameter int TrigBits = TrigBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic [1:0]         axis_i,
  input  logic signed [16:0] angle_deg_i,
  output logic               valid_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic               saturated_o
);

  side_t                      side_in;
  logic                       ang_vld, cor_vld;
  side_t                      ang_side, cor_side;
  logic signed [31:0]         ang_z;
  logic                       ang_flip, cor_flip;
  logic signed [TrigBits+2:0] cor_x, cor_y;

  // a new request can enter every cycle
  assign busy = 1'b0;

  assign side_in = '{axis: axis_i, vx: vec_x_i, vy: vec_y_i, vz: vec_z_i};

  rva_angle u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .side_i  (side_in),
    .angle_i (angle_deg_i),
    .valid_o (ang_vld),
    .side_o  (ang_side),
    .z_o     (ang_z),
    .flip_o  (ang_flip)
  );

  rva_cordic #(
    .TrigBits (TrigBits)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ang_vld),
    .side_i  (ang_side),
    .flip_i  (ang_flip),
    .z_i     (ang_z),
    .valid_o (cor_vld),
    .side_o  (cor_side),
    .flip_o  (cor_flip),
    .x_o     (cor_x),
    .y_o     (cor_y)
  );

  rva_mix #(
    .TrigBits (TrigBits)
  ) u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (cor_vld),
    .side_i      (cor_side),
    .flip_i      (cor_flip),
    .x_i         (cor_x),
    .y_i         (cor_y),
    .valid_o     (valid_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .saturated_o (saturated_o)
  );

endmodule

// ===== dv/rotate_vector_about_axis_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotate_vector_about_axis_tb
// Drives rotation requests through the axis rotator and checks every result
// against a cycle-free CORDIC prediction held in the bench. Directed corners
// first (axis codes, angle wrap, clipping), then random traffic with gaps.
// ----------------------------------------------------------------------------
module rotate_vector_about_axis_tb;
  import rva_pkg::*;

  localparam int     TrigBits   = TrigBitsDef;
  localparam int     Latency    = TrigBits + 7;
  localparam int     CycleLimit = 200000;
  localparam int     MaxPrinted = 30;
  localparam int     GainShift  = 32 - TrigBits;
  localparam int     AngleRight = TurnUnits / 4;
  localparam longint CoordMax   = 64'sh0000_0000_7FFF_FFFF;
  localparam longint CoordMin   = -64'sh0000_0000_8000_0000;
  localparam longint GainQ32    = 64'sd2608131496;

  // arctan(2^-i) in binary angle units, 2^32 per turn
  localparam logic [31:0] ArcStep [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1,         32'd0
  };

  typedef struct {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic [1:0]         axis;
    logic signed [16:0] angle;
  } rot_req_t;

  typedef struct {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
  } rot_result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic signed [31:0] vec_x_i     = '0;
  logic signed [31:0] vec_y_i     = '0;
  logic signed [31:0] vec_z_i     = '0;
  logic [1:0]         axis_i      = AxisX;
  logic signed [16:0] angle_deg_i = '0;
  logic               busy;
  logic               valid_o;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic signed [31:0] out_z_o;
  logic               saturated_o;

  rot_result_t rotated_pending [$];
  rot_result_t rotated_head;
  int          mismatches    = 0;
  int          rotations_ok  = 0;
  int          clipped_seen  = 0;
  int          requests_sent = 0;
  int          cycles        = 0;

  rotate_vector_about_axis #(
    .TrigBits(TrigBits)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .vec_x_i    (vec_x_i),
    .vec_y_i    (vec_y_i),
    .vec_z_i    (vec_z_i),
    .axis_i     (axis_i),
    .angle_deg_i(angle_deg_i),
    .valid_o    (valid_o),
    .out_x_o    (out_x_o),
    .out_y_o    (out_y_o),
    .out_z_o    (out_z_o),
    .saturated_o(saturated_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               rotated_pending.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // cos and sin of the angle, TrigBits fraction bits
  function automatic void cordic_cos_sin(input logic signed [16:0] angle,
                                         output longint cs, output longint sn);
    longint      turn_pos;
    longint      bin_wide;
    logic [31:0] bin;
    bit          flip;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    longint      lim;
    turn_pos = longint'(angle) % TurnUnits;
    if (turn_pos < 0) turn_pos += TurnUnits;
    bin_wide = ((turn_pos <<< 32) + TurnUnits / 2) / TurnUnits;
    bin = bin_wide[31:0];
    // second and third quadrant run half a turn away, sign fixed afterwards
    flip = (bin[31:30] == 2'd1) || (bin[31:30] == 2'd2);
    if (flip) bin ^= 32'h8000_0000;
    z = longint'(signed'(bin));
    x = (GainQ32 + (longint'(1) <<< (GainShift - 1))) >>> GainShift;
    y = 0;
    for (int i = 0; i < TrigBits; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ArcStep[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ArcStep[i]);
      end
    end
    lim = longint'(1) <<< TrigBits;
    if (x > lim) x = lim;
    if (x < -lim) x = -lim;
    if (y > lim) y = lim;
    if (y < -lim) y = -lim;
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  // a*c + b*s, rounded half up, clipped to 32 bits
  function automatic longint mix_round_clip(input longint a, input longint c,
                                            input longint b, input longint s,
                                            inout bit clipped);
    longint acc;
    acc = (a * c + b * s + (longint'(1) <<< (TrigBits - 1))) >>> TrigBits;
    if (acc > CoordMax) begin
      clipped = 1'b1;
      return CoordMax;
    end
    if (acc < CoordMin) begin
      clipped = 1'b1;
      return CoordMin;
    end
    return acc;
  endfunction

  function automatic rot_result_t predict_rotation(input rot_req_t req);
    rot_result_t res;
    longint      v [3];
    longint      o [3];
    longint      cs;
    longint      sn;
    int          ia;
    int          ib;
    bit          clipped;
    v[0] = longint'(req.vec_x);
    v[1] = longint'(req.vec_y);
    v[2] = longint'(req.vec_z);
    o = v;
    clipped = 1'b0;
    if (req.axis != AxisNone) begin
      ia = (int'(req.axis) + 1) % 3;
      ib = (int'(req.axis) + 2) % 3;
      cordic_cos_sin(req.angle, cs, sn);
      o[ia] = mix_round_clip(v[ia], cs, v[ib], sn, clipped);
      o[ib] = mix_round_clip(v[ia], -sn, v[ib], cs, clipped);
    end
    res.out_x     = o[0][31:0];
    res.out_y     = o[1][31:0];
    res.out_z     = o[2][31:0];
    res.saturated = clipped;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    if (mismatches < MaxPrinted) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // compare each result with the oldest prediction, then log accepted requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) begin
        if (rotated_pending.size() == 0) begin
          report_mismatch("unexpected result, out_x", longint'(out_x_o), 0);
        end else begin
          rotated_head = rotated_pending.pop_front();
          if (out_x_o !== rotated_head.out_x)
            report_mismatch("out_x", longint'(out_x_o), longint'(rotated_head.out_x));
          if (out_y_o !== rotated_head.out_y)
            report_mismatch("out_y", longint'(out_y_o), longint'(rotated_head.out_y));
          if (out_z_o !== rotated_head.out_z)
            report_mismatch("out_z", longint'(out_z_o), longint'(rotated_head.out_z));
          if (saturated_o !== rotated_head.saturated)
            report_mismatch("saturated", longint'(saturated_o),
                            longint'(rotated_head.saturated));
          rotations_ok++;
          if (rotated_head.saturated) clipped_seen++;
        end
      end
      if (start && !busy) begin
        rotated_pending.push_back(predict_rotation('{vec_x_i, vec_y_i, vec_z_i,
                                                     axis_i, angle_deg_i}));
      end
    end
  end

  task automatic send_request(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic signed [31:0] z, input logic [1:0] axis,
                              input logic signed [16:0] angle);
    vec_x_i     <= x;
    vec_y_i     <= y;
    vec_z_i     <= z;
    axis_i      <= axis;
    angle_deg_i <= angle;
    start       <= 1'b1;
    do @(posedge clk_i); while (busy);
    requests_sent++;
  endtask

  task automatic maybe_idle(input bit allowed);
    if (allowed && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [31:0] random_coord();
    case ($urandom_range(0, 5))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return int'($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
      3:       return int'($urandom_range(0, 32'h3FF_FFFF)) - 32'sh200_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [16:0] random_angle();
    case ($urandom_range(0, 7))
      0:       return 17'($urandom);
      1:       return 17'(AngleRight * (int'($urandom_range(0, 7)) - 4)
                          + int'($urandom_range(0, 2)) - 1);
      default: return 17'(int'($urandom_range(0, 2 * TurnUnits - 1)) - TurnUnits);
    endcase
  endfunction

  function automatic logic [1:0] random_axis();
    if ($urandom_range(0, 7) == 0) return AxisNone;
    return 2'($urandom_range(0, 2));
  endfunction

  task automatic test_axis_codes();
    logic [1:0] codes [4];
    codes = '{AxisX, AxisY, AxisZ, AxisNone};
    foreach (codes[k]) begin
      send_request(32'sd65536, 32'sd131072, -32'sd196608, codes[k], 17'(AngleRight));
      maybe_idle(1'b1);
      send_request(32'sd98304, -32'sd40000, 32'sd7, codes[k], 17'sd3840);
      maybe_idle(1'b1);
    end
    // tiny values exercise the rounding step
    send_request(32'sd1, -32'sd1, 32'sd0, AxisZ, 17'sd7680);
    maybe_idle(1'b1);
  endtask

  task automatic test_angle_extremes();
    logic signed [16:0] angles [9];
    angles = '{-17'sd65536, 17'sd65535, -17'(TurnUnits), 17'(TurnUnits - 1), 17'sd0,
               17'(2 * AngleRight), 17'(3 * AngleRight), -17'sd1, 17'sd1};
    foreach (angles[k]) begin
      send_request(32'sd1000000, -32'sd3000000, 32'sh7FFF_FFFF, AxisZ, angles[k]);
      maybe_idle(1'b1);
    end
  endtask

  task automatic test_saturation();
    send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sd0, AxisZ, 17'(AngleRight / 2));
    maybe_idle(1'b1);
    send_request(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, AxisX,
                 17'(AngleRight / 2));
    maybe_idle(1'b1);
    send_request(32'sh7FFF_FFFF, 32'sd5, 32'sh8000_0000, AxisY, -17'(AngleRight / 2));
    maybe_idle(1'b1);
    send_request(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, AxisZ, 17'(AngleRight * 3 / 2));
    maybe_idle(1'b1);
  endtask

  // gaps come and go in blocks so some stretches run at full rate
  task automatic test_random_vectors(input int count);
    for (int n = 0; n < count; n++) begin
      send_request(random_coord(), random_coord(), random_coord(), random_axis(),
                   random_angle());
      maybe_idle(((n / 50) % 3) != 2);
    end
  endtask

  task automatic test_back_to_back(input int count);
    for (int n = 0; n < count; n++) begin
      send_request(random_coord(), random_coord(), random_coord(), random_axis(),
                   random_angle());
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (rotated_pending.size() != 0) @(posedge clk_i);
    // catch any stray result still in the pipe
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_axis_codes();
    test_angle_extremes();
    test_saturation();
    test_random_vectors(850);
    test_back_to_back(150);
    drain_results();
    $display("%0d requests sent, %0d results checked, %0d of them clipped", requests_sent,
             rotations_ok, clipped_seen);
    $display("covered all axis codes, wrapped angles, quadrant edges and random gaps");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
